// ----- hw/rtl/fic_pkg.sv -----
// Package for the Fenwick-tree inversion counter.
// Holds the word types of both channels, the front-to-back command and the
// state encoding. Depends on nothing.
`default_nettype none

package fic_pkg;

   // Default sizes of the tree.
   localparam int DEF_TABLE_SIZE = 1024;
   localparam int DEF_COUNT_BITS = 32;

   // Fixed field widths of the channel words.
   localparam int VALUE_BITS = 10;
   localparam int INV_BITS   = 63;
   localparam int ITEM_BITS  = 32;

   // Largest totals before saturation.
   localparam logic [INV_BITS-1:0]  INV_MAX  = '1;
   localparam logic [ITEM_BITS-1:0] ITEM_MAX = '1;

   // Input word.
   typedef struct packed {
      logic                  action;
      logic [VALUE_BITS-1:0] value;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [INV_BITS-1:0]  inversions;
      logic [ITEM_BITS-1:0] items_seen;
      logic                 value_rejected;
   } rsp_type;

   // Classification made by the front end.
   typedef enum logic [1:0] {
      CMD_INSERT,
      CMD_CLEAR,
      CMD_REJECT
   } cmd_kind_type;

   // Command handed from the front end to the tree engine.
   typedef struct packed {
      cmd_kind_type          kind;
      logic [VALUE_BITS-1:0] value;
   } cmd_type;

   // Tree engine states.
   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_QUERY,
      ST_DIFF,
      ST_ACCUM,
      ST_UPDATE,
      ST_RESULT
   } back_state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/fic_front.sv -----
// Front end of the inversion counter: takes input words, classifies them
// and holds them in a two-entry command queue. Depends on fic_pkg.
`default_nettype none

module fic_front #(
   parameter int TABLE_SIZE = fic_pkg::DEF_TABLE_SIZE
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire fic_pkg::req_type req_data,
   output logic                  cmd_valid,
   output fic_pkg::cmd_type      cmd_data,
   input  wire logic             cmd_pop
);

   fic_pkg::cmd_type queue_ff [2];
   logic             head_ff, head_in;
   logic             tail_ff, tail_in;
   logic [1:0]       count_ff, count_in;
   fic_pkg::cmd_type cmd_new;
   logic             push_ok;
   logic             pop_ok;

   // Classify the incoming word.
   always_comb begin
      cmd_new.value = req_data.value;
      if (req_data.action) begin
         cmd_new.kind = fic_pkg::CMD_CLEAR;
      end else if (req_data.value == '0 ||
                   32'(req_data.value) >= 32'(TABLE_SIZE)) begin
         cmd_new.kind = fic_pkg::CMD_REJECT;
      end else begin
         cmd_new.kind = fic_pkg::CMD_INSERT;
      end
   end

   // Queue pointers and fill count.
   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = queue_ff[head_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_comb begin
      head_in  = pop_ok  ? !head_ff : head_ff;
      tail_in  = push_ok ? !tail_ff : tail_ff;
      count_in = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 2'd1;
      end else if (!push_ok && pop_ok) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[tail_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/fic_back.sv -----
// Tree engine of the inversion counter: owns the count tree memory, runs the
// prefix and update walks, keeps the totals and holds the result word.
// Depends on fic_pkg.
`default_nettype none

module fic_back #(
   parameter int TABLE_SIZE = fic_pkg::DEF_TABLE_SIZE,
   parameter int COUNT_BITS = fic_pkg::DEF_COUNT_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire fic_pkg::cmd_type cmd_data,
   output logic                  cmd_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output fic_pkg::rsp_type      rsp_data
);

   localparam int PW       = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1;
   localparam int SUM_BITS = COUNT_BITS + $clog2(PW + 1);
   localparam int CMP_BITS = (SUM_BITS > fic_pkg::ITEM_BITS) ? SUM_BITS : fic_pkg::ITEM_BITS;
   localparam logic [PW:0]           POS_ONE   = (PW + 1)'(1);
   localparam logic [PW:0]           POS_LIMIT = (PW + 1)'(TABLE_SIZE);
   localparam logic [PW-1:0]         SWEEP_END = PW'(TABLE_SIZE - 1);
   localparam logic [COUNT_BITS-1:0] ENTRY_ONE = COUNT_BITS'(1);

   fic_pkg::back_state_type state_ff, state_in;
   logic [PW:0]                    pos_ff, pos_in;
   logic [PW:0]                    val_ff, val_in;
   logic [SUM_BITS-1:0]            sum_ff, sum_in;
   logic [fic_pkg::ITEM_BITS-1:0]  greater_ff, greater_in;
   logic [fic_pkg::INV_BITS-1:0]   inv_ff, inv_in;
   logic [fic_pkg::ITEM_BITS-1:0]  items_ff, items_in;
   logic                           rd_pend_ff, rd_pend_in;
   logic [PW-1:0]                  wr_addr_ff, wr_addr_in;
   logic [PW-1:0]                  sweep_ff, sweep_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   fic_pkg::rsp_type               rsp_data_ff, rsp_data_in;
   logic [COUNT_BITS-1:0]          rd_data_ff;

   logic [COUNT_BITS-1:0]          tree_mem [TABLE_SIZE];
   logic [PW-1:0]                  mem_rd_addr;
   logic                           mem_wr_en;
   logic [PW-1:0]                  mem_wr_addr;
   logic [COUNT_BITS-1:0]          mem_wr_data;

   logic                           out_free;
   logic [COUNT_BITS-1:0]          entry_inc;
   logic [CMP_BITS-1:0]            items_ext;
   logic [CMP_BITS-1:0]            sum_ext;
   logic [fic_pkg::INV_BITS:0]     inv_sum;

   assign out_free  = !rsp_valid_ff || rsp_pop;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Saturating increment of the entry just read.
   assign entry_inc = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + ENTRY_ONE;

   // Operands for the count of earlier, larger elements.
   assign items_ext = CMP_BITS'(items_ff);
   assign sum_ext   = CMP_BITS'(sum_ff);
   assign inv_sum   = {1'b0, inv_ff} + (fic_pkg::INV_BITS + 1)'(greater_ff);

   // Next state, walk control and memory port control.
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      sum_in       = sum_ff;
      greater_in   = greater_ff;
      inv_in       = inv_ff;
      items_in     = items_ff;
      rd_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      sweep_in     = sweep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;
      mem_rd_addr  = pos_ff[PW-1:0];
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wr_addr_ff;
      mem_wr_data  = entry_inc;

      case (state_ff)
         fic_pkg::ST_SWEEP: begin
            // Zero one tree entry per cycle.
            mem_wr_en   = 1'b1;
            mem_wr_addr = sweep_ff;
            mem_wr_data = '0;
            sweep_in    = sweep_ff + PW'(1);
            if (sweep_ff == SWEEP_END) begin
               sweep_in = '0;
               state_in = fic_pkg::ST_IDLE;
            end
         end
         fic_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd_data.kind)
                  fic_pkg::CMD_INSERT: begin
                     cmd_pop  = 1'b1;
                     pos_in   = (PW + 1)'(cmd_data.value);
                     val_in   = (PW + 1)'(cmd_data.value);
                     sum_in   = '0;
                     state_in = fic_pkg::ST_QUERY;
                  end
                  fic_pkg::CMD_CLEAR: begin
                     if (out_free) begin
                        cmd_pop                    = 1'b1;
                        inv_in                     = '0;
                        items_in                   = '0;
                        rsp_valid_in               = 1'b1;
                        rsp_data_in.inversions     = '0;
                        rsp_data_in.items_seen     = '0;
                        rsp_data_in.value_rejected = 1'b0;
                        sweep_in                   = '0;
                        state_in                   = fic_pkg::ST_SWEEP;
                     end
                  end
                  default: begin
                     // Rejected value: report the unchanged totals.
                     if (out_free) begin
                        cmd_pop                    = 1'b1;
                        rsp_valid_in               = 1'b1;
                        rsp_data_in.inversions     = inv_ff;
                        rsp_data_in.items_seen     = items_ff;
                        rsp_data_in.value_rejected = 1'b1;
                     end
                  end
               endcase
            end
         end
         fic_pkg::ST_QUERY: begin
            // Downward walk: one read issued and one entry summed per cycle.
            if (pos_ff != '0) begin
               rd_pend_in = 1'b1;
               pos_in     = pos_ff & (pos_ff - POS_ONE);
            end
            if (rd_pend_ff) begin
               sum_in = sum_ff + SUM_BITS'(rd_data_ff);
            end
            if (pos_ff == '0 && !rd_pend_ff) begin
               state_in = fic_pkg::ST_DIFF;
            end
         end
         fic_pkg::ST_DIFF: begin
            // Earlier elements greater than the value, floored at zero.
            greater_in = (items_ext > sum_ext) ?
                         fic_pkg::ITEM_BITS'(items_ext - sum_ext) : '0;
            state_in   = fic_pkg::ST_ACCUM;
         end
         fic_pkg::ST_ACCUM: begin
            inv_in   = inv_sum[fic_pkg::INV_BITS] ? fic_pkg::INV_MAX :
                       inv_sum[fic_pkg::INV_BITS-1:0];
            items_in = (items_ff == fic_pkg::ITEM_MAX) ? items_ff :
                       items_ff + fic_pkg::ITEM_BITS'(1);
            pos_in   = val_ff;
            state_in = fic_pkg::ST_UPDATE;
         end
         fic_pkg::ST_UPDATE: begin
            // Upward walk: read an entry, write it back incremented in the next cycle.
            if (pos_ff < POS_LIMIT) begin
               rd_pend_in = 1'b1;
               wr_addr_in = pos_ff[PW-1:0];
               pos_in     = pos_ff + (pos_ff & (~pos_ff + POS_ONE));
            end
            if (rd_pend_ff) begin
               mem_wr_en = 1'b1;
            end
            if (!(pos_ff < POS_LIMIT) && !rd_pend_ff) begin
               state_in = fic_pkg::ST_RESULT;
            end
         end
         fic_pkg::ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.inversions     = inv_ff;
               rsp_data_in.items_seen     = items_ff;
               rsp_data_in.value_rejected = 1'b0;
               state_in                   = fic_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fic_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state and totals.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fic_pkg::ST_SWEEP;
         sweep_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         inv_ff       <= '0;
         items_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         inv_ff       <= inv_in;
         items_ff     <= items_in;
      end
   end

   // Walk registers and the result word.
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      sum_ff      <= sum_in;
      greater_ff  <= greater_in;
      wr_addr_ff  <= wr_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Count tree memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         tree_mem[mem_wr_addr] <= mem_wr_data;
      end
      rd_data_ff <= tree_mem[mem_rd_addr];
   end

endmodule

`default_nettype wire

// ----- hw/rtl/fenwick_inversion_counter_top.sv -----
// Top level of the Fenwick-tree inversion counter.
// Joins the front end (fic_front) and the tree engine (fic_back); uses fic_pkg.
`default_nettype none

// Streaming inversion counter. Each word either inserts a value, which must
// lie in 1..TABLE_SIZE-1 and is otherwise reported as rejected, or clears the
// tree and totals. Every word yields one result word with the running
// inversion total and the count of inserted values, both saturating. Words
// enter a two-entry command queue, so the input side keeps taking words while
// a result waits, until the queue is full. An insert is taken from the queue,
// then walks down the tree summing the entries at or below its value, forms
// the count of earlier, larger values, adds it to the inversion total, walks
// up the tree incrementing entries and finally writes the result word. The
// two walks together touch at most log2(TABLE_SIZE) + 1 entries, one at a
// time through the single read port of the tree memory. A clear is followed
// by a sweep that zeroes the tree entry by entry; the same sweep runs after
// reset, and no insert is processed until it ends.
module fenwick_inversion_counter_top #(
   parameter int TABLE_SIZE = fic_pkg::DEF_TABLE_SIZE,
   parameter int COUNT_BITS = fic_pkg::DEF_COUNT_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire fic_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output fic_pkg::rsp_type      rsp_data
);

   logic             cmd_valid;
   fic_pkg::cmd_type cmd_data;
   logic             cmd_pop;

   // Input classification and command queue.
   fic_front #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_valid(cmd_valid),
      .cmd_data (cmd_data),
      .cmd_pop  (cmd_pop)
   );

   // Tree walks, totals and result word.
   fic_back #(
      .TABLE_SIZE(TABLE_SIZE),
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(cmd_valid),
      .cmd_data (cmd_data),
      .cmd_pop  (cmd_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
